// ===== hw/rtl/voxel_face_visibility_core_macros.svh =====
// assertion macros shared by the voxel face visibility block
`ifndef VOXEL_FACE_VISIBILITY_CORE_MACROS_SVH
`define VOXEL_FACE_VISIBILITY_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define VFV_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("voxel face visibility check failed");

// next-cycle implication, sampled on clk, off during reset
`define VFV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("voxel face visibility check failed");

`endif

// ===== hw/rtl/vfv_pkg.sv =====
// shared types and constants for the voxel face visibility block
package vfv_pkg;

    // coordinate math width: holds pos + 1 and wraps pos - 1 above any grid size
    localparam int COORD_W = 9;
    typedef logic [COORD_W-1:0] coord_t;

    // position field width of the input beat
    localparam int POS_W = 4;

    // number of faces per cell
    localparam int NUM_DIRS = 6;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // scan step codes: the cell itself, then one neighbor per face bit
    typedef logic [2:0] step_t;
    localparam step_t STEP_CENTER = 3'd0;
    localparam step_t STEP_PZ     = 3'd1;
    localparam step_t STEP_NZ     = 3'd2;
    localparam step_t STEP_NX     = 3'd3;
    localparam step_t STEP_PX     = 3'd4;
    localparam step_t STEP_PY     = 3'd5;
    localparam step_t STEP_NY     = 3'd6;
    localparam step_t STEP_LAST   = STEP_NY;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // occupancy store control
    typedef struct packed {
        logic wr_en;
        logic wr_bit;
        logic rd_en;
    } occ_ctrl_t;

endpackage

// ===== hw/rtl/vfv_occ_store.sv =====
// occupancy bit memory with a clearing sweep after reset
module vfv_occ_store
    import vfv_pkg::*;
#(
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  occ_ctrl_t         ctrl,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic              rd_data,
    output logic              clr_busy
);

    localparam int DEPTH = 1 << ADDR_W;

    logic              mem [DEPTH];
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              clr_busy_reg;
    logic              clr_busy_next;
    logic              rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_wbit;

    // clearing sweep walks every entry once after reset
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == {ADDR_W{1'b1}})
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    // write port: sweep has priority
    always_comb
    begin
        mem_we    = clr_busy_reg || ctrl.wr_en;
        mem_waddr = clr_busy_reg ? clr_addr_reg : wr_addr;
        mem_wbit  = clr_busy_reg ? 1'b0 : ctrl.wr_bit;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wbit;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

// ===== hw/rtl/voxel_face_visibility_core.sv =====
// voxel face visibility: grid store, face scan sequencer and result register
//
// Input channel (in_valid / in_stall): one beat is op, pos_x, pos_y, pos_z,
// set_present, set_type. op write stores occupancy and type of one cell; op
// query asks for one cell. Output channel (out_valid / out_stall): one beat
// per input beat with is_present, is_visible, face_mask and block_type.
// A write or an out-of-grid position answers with all fields zero.
// A query reads the occupancy memory through its single read port up to
// seven times (the cell and its six neighbors; neighbors outside the grid
// are not read), one read per cycle, then passes a drain step and a finish
// step; a write or out-of-grid item goes straight to the finish step, where
// the result is loaded. The block takes one item at a time.
// After reset the occupancy memory is swept clear, one entry per cycle over
// all 2^(clog2(SIZE_X)+clog2(SIZE_Y)+clog2(SIZE_Z)) entries, 4096 at the
// default size; in_stall stays high meanwhile.
// A finished result waits in the output register while out_stall is high;
// the next item is accepted meanwhile, and its result waits for the slot.
`include "voxel_face_visibility_core_macros.svh"

module voxel_face_visibility_core
    import vfv_pkg::*;
#(
    parameter int SIZE_X    = 16,
    parameter int SIZE_Y    = 16,
    parameter int SIZE_Z    = 16,
    parameter int TYPE_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 op,
    input  logic [POS_W-1:0]     pos_x,
    input  logic [POS_W-1:0]     pos_y,
    input  logic [POS_W-1:0]     pos_z,
    input  logic                 set_present,
    input  logic [TYPE_BITS-1:0] set_type,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 is_present,
    output logic                 is_visible,
    output logic [NUM_DIRS-1:0]  face_mask,
    output logic [TYPE_BITS-1:0] block_type
);

    localparam int XW     = $clog2(SIZE_X);
    localparam int YW     = $clog2(SIZE_Y);
    localparam int ZW     = $clog2(SIZE_Z);
    localparam int ADDR_W = XW + YW + ZW;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam coord_t LIM_X = COORD_W'(SIZE_X);
    localparam coord_t LIM_Y = COORD_W'(SIZE_Y);
    localparam coord_t LIM_Z = COORD_W'(SIZE_Z);

    state_t                state_reg, state_next;
    step_t                 step_reg, step_next;
    step_t                 col_step_reg, col_step_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic                  rd_inb_reg, rd_inb_next;
    coord_t                x_reg, x_next;
    coord_t                y_reg, y_next;
    coord_t                z_reg, z_next;
    logic                  present_reg, present_next;
    logic [NUM_DIRS-1:0]   mask_reg, mask_next;
    logic [TYPE_BITS-1:0]  type_rd_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_present_reg, out_present_next;
    logic                  out_visible_reg, out_visible_next;
    logic [NUM_DIRS-1:0]   out_mask_reg, out_mask_next;
    logic [TYPE_BITS-1:0]  out_type_reg, out_type_next;

    logic [TYPE_BITS-1:0]  type_mem [DEPTH];

    logic                  accept;
    logic                  clr_busy;
    logic                  occ_rd_data;
    occ_ctrl_t             occ_ctrl;
    coord_t                in_x, in_y, in_z;
    logic                  in_grid;
    logic [ADDR_W-1:0]     wr_addr;
    coord_t                nb_x, nb_y, nb_z;
    logic                  nb_in;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  type_rd_en;
    logic                  out_load;
    logic [2:0]            col_idx;

    // input beat decode
    always_comb
    begin
        in_stall = clr_busy || (state_reg != ST_IDLE);
        accept   = in_valid && !in_stall;
        in_x     = COORD_W'(pos_x);
        in_y     = COORD_W'(pos_y);
        in_z     = COORD_W'(pos_z);
        in_grid  = (in_x < LIM_X) && (in_y < LIM_Y) && (in_z < LIM_Z);
        wr_addr  = {in_x[XW-1:0], in_y[YW-1:0], in_z[ZW-1:0]};
    end

    // neighbor position for the current scan step
    always_comb
    begin
        nb_x = x_reg;
        nb_y = y_reg;
        nb_z = z_reg;
        unique case (step_reg)
            STEP_CENTER: ;
            STEP_PZ:     nb_z = z_reg + 1'b1;
            STEP_NZ:     nb_z = z_reg - 1'b1;
            STEP_NX:     nb_x = x_reg - 1'b1;
            STEP_PX:     nb_x = x_reg + 1'b1;
            STEP_PY:     nb_y = y_reg + 1'b1;
            STEP_NY:     nb_y = y_reg - 1'b1;
            default:     ;
        endcase
        // pos - 1 from zero wraps above every grid size
        nb_in   = (nb_x < LIM_X) && (nb_y < LIM_Y) && (nb_z < LIM_Z);
        rd_addr = {nb_x[XW-1:0], nb_y[YW-1:0], nb_z[ZW-1:0]};
    end

    // sequencer: next state, store control, face collection, result load
    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        col_step_next    = col_step_reg;
        rd_pend_next     = 1'b0;
        rd_inb_next      = rd_inb_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        z_next           = z_reg;
        present_next     = present_reg;
        mask_next        = mask_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_present_next = out_present_reg;
        out_visible_next = out_visible_reg;
        out_mask_next    = out_mask_reg;
        out_type_next    = out_type_reg;
        occ_ctrl.wr_en   = accept && (op == OP_WRITE) && in_grid;
        occ_ctrl.wr_bit  = set_present;
        occ_ctrl.rd_en   = 1'b0;
        type_rd_en       = 1'b0;
        out_load         = 1'b0;
        col_idx          = 3'(col_step_reg - 3'd1);

        // fold in the read issued last cycle
        if (rd_pend_reg)
        begin
            if (col_step_reg == STEP_CENTER)
            begin
                present_next = occ_rd_data;
            end
            else
            begin
                mask_next[col_idx] = !(rd_inb_reg && occ_rd_data);
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    x_next       = in_x;
                    y_next       = in_y;
                    z_next       = in_z;
                    present_next = 1'b0;
                    mask_next    = '0;
                    step_next    = STEP_CENTER;
                    if ((op == OP_QUERY) && in_grid)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_READ:
            begin
                occ_ctrl.rd_en = nb_in;
                type_rd_en     = (step_reg == STEP_CENTER);
                rd_pend_next   = 1'b1;
                rd_inb_next    = nb_in;
                col_step_next  = step_reg;
                step_next      = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // result register
        if (out_load)
        begin
            out_valid_next   = 1'b1;
            out_present_next = present_reg;
            out_visible_next = present_reg && (mask_reg != '0);
            out_mask_next    = present_reg ? mask_reg : '0;
            out_type_next    = present_reg ? type_rd_reg : '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        step_reg        <= step_next;
        col_step_reg    <= col_step_next;
        rd_inb_reg      <= rd_inb_next;
        x_reg           <= x_next;
        y_reg           <= y_next;
        z_reg           <= z_next;
        present_reg     <= present_next;
        mask_reg        <= mask_next;
        out_present_reg <= out_present_next;
        out_visible_reg <= out_visible_next;
        out_mask_reg    <= out_mask_next;
        out_type_reg    <= out_type_next;
    end

    // type memory: written with the occupancy bit, read at the scan center
    always_ff @(posedge clk)
    begin
        if (occ_ctrl.wr_en)
        begin
            type_mem[wr_addr] <= set_type;
        end
    end

    always_ff @(posedge clk)
    begin
        if (type_rd_en)
        begin
            type_rd_reg <= type_mem[rd_addr];
        end
    end

    // occupancy memory
    vfv_occ_store #(
        .ADDR_W (ADDR_W)
    ) u_occ_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (occ_ctrl),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr),
        .rd_data  (occ_rd_data),
        .clr_busy (clr_busy)
    );

    // output beat
    assign out_valid  = out_valid_reg;
    assign is_present = out_present_reg;
    assign is_visible = out_visible_reg;
    assign face_mask  = out_mask_reg;
    assign block_type = out_type_reg;

    // checks
    `VFV_ASSERT_IMPLY(a_visible_rule, out_valid, is_visible == (is_present && face_mask != '0))
    `VFV_ASSERT_IMPLY(a_absent_zero, out_valid && !is_present, face_mask == '0 && block_type == '0)
    `VFV_ASSERT_IMPLY(a_clear_quiet, clr_busy, state_reg == ST_IDLE && !out_valid_reg)
    `VFV_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state_reg != ST_IDLE)

endmodule
